### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the camera basis block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge while out of reset.
`define ECB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define ECB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ECB_ASSERT(lbl, clk, rst_n, prop, msg)
`define ECB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/ecb_pkg.sv
// ----------------------------------------------------------------------------
// ecb_pkg
// Shared widths, types, codes and tables of the camera basis block.
// ----------------------------------------------------------------------------
package ecb_pkg;

    localparam int ANGLE_W    = 16;
    localparam int FRAC_W     = 14;
    localparam int VEC_W      = FRAC_W + 2;
    localparam int COORD_W    = 32;
    localparam int TRIG_ITER  = 16;
    localparam int CORDIC_W   = 34;
    localparam int TRIG_SHIFT = 30 - FRAC_W;
    localparam int MAG_W      = COORD_W + 1;
    localparam int NRM_W      = 24;
    localparam int ROOT_W     = NRM_W + 1;
    localparam int SQ_W       = 2 * ROOT_W;
    localparam int DIV_NUM_W  = NRM_W + FRAC_W + 1;
    localparam int QUO_W      = 16;
    localparam int MUL_W      = 25;
    localparam int PROD_W     = 2 * MUL_W;

    localparam logic signed [CORDIC_W-1:0] CORDIC_K = 34'sd652032874;

    typedef logic signed [VEC_W-1:0]   vec_t;
    typedef logic signed [VEC_W+1:0]   vec_wide_t;
    typedef logic [ANGLE_W-1:0]        angle_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [1:0]                reg_addr_t;

    localparam vec_t      VEC_ONE      = 16'sd16384;
    localparam vec_wide_t VEC_WIDE_ONE = 18'sd16384;

    typedef enum logic [1:0] {
        REG_POS_X = 2'd0,
        REG_POS_Y = 2'd1,
        REG_POS_Z = 2'd2
    } reg_idx_t;

    localparam logic CMD_ORIENT = 1'b0;
    localparam logic CMD_LOOK   = 1'b1;

    // Arctangent of 2^-i as a 32-bit binary angle.
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] t;
        case (i)
            5'd0:    t = 32'h20000000;
            5'd1:    t = 32'h12E4051E;
            5'd2:    t = 32'h09FB385B;
            5'd3:    t = 32'h051111D4;
            5'd4:    t = 32'h028B0D43;
            5'd5:    t = 32'h0145D7E1;
            5'd6:    t = 32'h00A2F61E;
            5'd7:    t = 32'h00517C55;
            5'd8:    t = 32'h0028BE53;
            5'd9:    t = 32'h00145F2F;
            5'd10:   t = 32'h000A2F98;
            5'd11:   t = 32'h000517CC;
            5'd12:   t = 32'h00028BE6;
            5'd13:   t = 32'h000145F3;
            5'd14:   t = 32'h0000A2F9;
            5'd15:   t = 32'h0000517C;
            5'd16:   t = 32'h000028BE;
            5'd17:   t = 32'h0000145F;
            5'd18:   t = 32'h00000A2F;
            5'd19:   t = 32'h00000517;
            5'd20:   t = 32'h0000028B;
            5'd21:   t = 32'h00000145;
            5'd22:   t = 32'h000000A2;
            5'd23:   t = 32'h00000051;
            5'd24:   t = 32'h00000028;
            5'd25:   t = 32'h00000014;
            5'd26:   t = 32'h0000000A;
            5'd27:   t = 32'h00000005;
            5'd28:   t = 32'h00000002;
            5'd29:   t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

    // Saturate a widened component to the unit range.
    function automatic vec_t clamp_vec(input vec_wide_t v);
        vec_t r;
        if (v > VEC_WIDE_ONE)
            r = VEC_ONE;
        else if (v < -VEC_WIDE_ONE)
            r = -VEC_ONE;
        else
            r = v[VEC_W-1:0];
        return r;
    endfunction

endpackage

### rtl/ecb_if.sv
// ----------------------------------------------------------------------------
// ecb_if
// Valid/ready channels of the camera basis block: config, request, result.
// ----------------------------------------------------------------------------
interface ecb_cfg_if;
    import ecb_pkg::*;
    logic      valid;
    logic      ready;
    reg_addr_t addr;
    coord_t    data;
    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

interface ecb_in_if;
    import ecb_pkg::*;
    logic   valid;
    logic   ready;
    logic   command;
    angle_t pitch;
    angle_t yaw;
    angle_t roll;
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
    modport source (output valid, output command, output pitch, output yaw, output roll,
                    output center_x, output center_y, output center_z, input ready);
    modport sink   (input valid, input command, input pitch, input yaw, input roll,
                    input center_x, input center_y, input center_z, output ready);
endinterface

interface ecb_out_if;
    import ecb_pkg::*;
    logic valid;
    logic ready;
    vec_t dir_x;
    vec_t dir_y;
    vec_t dir_z;
    vec_t up_x;
    vec_t up_y;
    vec_t up_z;
    vec_t side_x;
    vec_t side_y;
    vec_t side_z;
    logic degenerate;
    modport source (output valid, output dir_x, output dir_y, output dir_z,
                     output up_x, output up_y, output up_z,
                     output side_x, output side_y, output side_z,
                     output degenerate, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z,
                     input up_x, input up_y, input up_z,
                     input side_x, input side_y, input side_z,
                     input degenerate, output ready);
endinterface

### rtl/ecb_cordic.sv
// ----------------------------------------------------------------------------
// ecb_cordic
// Iterative rotation CORDIC: sine and cosine of one binary angle.
// ----------------------------------------------------------------------------
module ecb_cordic #(
    parameter int ITER = ecb_pkg::TRIG_ITER
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ecb_pkg::angle_t angle,
    output logic           done,
    output ecb_pkg::vec_t  sin_val,
    output ecb_pkg::vec_t  cos_val
);
    import ecb_pkg::*;

    localparam int CNT_W = $clog2(ITER + 1);
    localparam logic signed [CORDIC_W-1:0] RND_HALF = 34'sd1 <<< (TRIG_SHIFT - 1);
    localparam logic signed [CORDIC_W-1:0] SAT_HI   = 34'sd16384;

    logic                       busy_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg, z_reg;
    logic                       neg_reg;
    logic                       done_reg;
    vec_t                       sin_reg, cos_reg;

    logic [31:0]                a32, a_fold;
    logic                       fold;
    logic [4:0]                 sh;
    logic signed [CORDIC_W-1:0] dx, dy, t, z0, x_rnd, y_rnd;
    vec_t                       x_sat, y_sat;

    always_comb
    begin
        a32    = {angle, {(32 - ANGLE_W){1'b0}}};
        fold   = a32[31] ^ a32[30];
        a_fold = fold ? a32 + 32'h80000000 : a32;
        z0     = {{(CORDIC_W - 32){a_fold[31]}}, a_fold};
        sh     = 5'(cnt_reg);
        dx     = y_reg >>> sh;
        dy     = x_reg >>> sh;
        t      = {{(CORDIC_W - 32){1'b0}}, atan_entry(sh)};
        x_rnd  = (x_reg + RND_HALF) >>> TRIG_SHIFT;
        y_rnd  = (y_reg + RND_HALF) >>> TRIG_SHIFT;
        if (x_rnd > SAT_HI)
            x_sat = VEC_ONE;
        else if (x_rnd < -SAT_HI)
            x_sat = -VEC_ONE;
        else
            x_sat = x_rnd[VEC_W-1:0];
        if (y_rnd > SAT_HI)
            y_sat = VEC_ONE;
        else if (y_rnd < -SAT_HI)
            y_sat = -VEC_ONE;
        else
            y_sat = y_rnd[VEC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            neg_reg  <= 1'b0;
            done_reg <= 1'b0;
            sin_reg  <= '0;
            cos_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                x_reg    <= CORDIC_K;
                y_reg    <= '0;
                z_reg    <= z0;
                neg_reg  <= fold;
            end
            else if (busy_reg)
            begin
                if (cnt_reg != CNT_W'(ITER))
                begin
                    if (!z_reg[CORDIC_W-1])
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - t;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + t;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    cos_reg  <= neg_reg ? -x_sat : x_sat;
                    sin_reg  <= neg_reg ? -y_sat : y_sat;
                end
            end
        end
    end

    assign done    = done_reg;
    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

### rtl/ecb_isqrt.sv
// ----------------------------------------------------------------------------
// ecb_isqrt
// Bit-serial floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module ecb_isqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ecb_pkg::SQ_W-1:0]  rad,
    output logic                      done,
    output logic [ecb_pkg::ROOT_W-1:0] root
);
    import ecb_pkg::*;

    localparam logic [SQ_W-1:0] BIT_TOP = SQ_W'(1) << (SQ_W - 2);

    logic              busy_reg;
    logic              done_reg;
    logic [SQ_W-1:0]   v_reg, r_reg, bit_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SQ_W-1:0]   trial;
    logic              take;

    always_comb
    begin
        trial = r_reg + bit_reg;
        take  = (v_reg >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            v_reg    <= '0;
            r_reg    <= '0;
            bit_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                v_reg    <= rad;
                r_reg    <= '0;
                bit_reg  <= BIT_TOP;
            end
            else if (busy_reg)
            begin
                if (bit_reg != '0)
                begin
                    if (take)
                    begin
                        v_reg <= v_reg - trial;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end
                    else
                        r_reg <= r_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    root_reg <= r_reg[ROOT_W-1:0];
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/ecb_div.sv
// ----------------------------------------------------------------------------
// ecb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ecb_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ecb_pkg::DIV_NUM_W-1:0] num,
    input  logic [ecb_pkg::ROOT_W-1:0]   den,
    output logic                         done,
    output logic [ecb_pkg::QUO_W-1:0]    quo
);
    import ecb_pkg::*;

    localparam int SH_W  = ROOT_W + QUO_W - 1;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_NUM_W-1:0] rem_reg;
    logic [SH_W-1:0]      den_reg;
    logic [QUO_W-1:0]     q_reg;
    logic                 ge;

    assign ge = ({{(SH_W - DIV_NUM_W){1'b0}}, rem_reg} >= den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= num;
                den_reg  <= {den, {(QUO_W - 1){1'b0}}};
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg != CNT_W'(QUO_W))
                begin
                    if (ge)
                        rem_reg <= rem_reg - den_reg[DIV_NUM_W-1:0];
                    q_reg   <= {q_reg[QUO_W-2:0], ge};
                    den_reg <= den_reg >> 1;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

### rtl/euler_camera_basis.sv
// ----------------------------------------------------------------------------
// euler_camera_basis
// Camera orientation unit: keeps direction, up and side in Q1.14 and
// updates them from Euler angles or from a look-at point.
// ----------------------------------------------------------------------------
//
//  channel | dir  | contents
//  --------+------+---------------------------------------------------------
//  cfg     | sink | addr, data: camera position x/y/z (Q16.16), always ready
//  item    | sink | command, pitch, yaw, roll, center_x/y/z
//  result  | src  | dir_x..z, up_x..z, side_x..z, degenerate
//
// An orientation request runs three angles through the shared CORDIC,
// then 15 products through the shared multiplier, and then loads the
// output register. A look-at request does the zero check, the scaling
// shifts (up to 23), three squares, the square root, three divisions and
// the output load; a zero difference goes from the zero check straight to
// the output load.
// The item channel is ready only in idle; a finished result may wait in the
// output register while the next request is already being worked on.
// Reset restores the default basis (forward -z, up +y, side +x), position 0.
`include "assert_macros.svh"

module euler_camera_basis #(
    parameter int TRIG_ITERATIONS = ecb_pkg::TRIG_ITER
) (
    input  logic      clk,
    input  logic      rst_n,
    ecb_cfg_if.sink   cfg,
    ecb_in_if.sink    item,
    ecb_out_if.source result
);
    import ecb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRIG,
        S_MUL,
        S_CHECK,
        S_SCALE,
        S_SQUARE,
        S_ROOT,
        S_DIV,
        S_DONE
    } state_t;

    // Multiplier program for the orientation update.
    typedef enum logic [3:0] {
        M_FX, M_FZ, M_T1A, M_T2A, M_UX, M_UY, M_T1B, M_T2B, M_UZ,
        M_SXA, M_SXB, M_SYA, M_SYB, M_SZA, M_SZB
    } mstep_t;

    localparam logic signed [31:0] HALF32 = 32'sd1 <<< (FRAC_W - 1);

    state_t                   state_reg;
    mstep_t                   step_reg;
    logic                     phase_reg;
    logic [1:0]               k_reg;
    coord_t                   pos_reg  [3];
    vec_t                     fwd_reg  [3];
    vec_t                     up_reg   [3];
    vec_t                     side_reg [3];
    angle_t                   ang_reg  [3];
    vec_t                     sin_reg  [3];
    vec_t                     cos_reg  [3];
    logic                     trig_start_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [31:0]       acc_reg;
    vec_t                     t1_reg, t2_reg;
    logic [MAG_W-1:0]         mag_reg [3];
    logic                     neg_reg [3];
    logic [SQ_W-1:0]          sum_reg;
    logic                     sqrt_start_reg;
    logic                     div_start_reg;
    logic                     degen_reg;
    logic                     out_valid_reg;
    vec_t                     out_vec_reg [9];
    logic                     out_degen_reg;

    logic signed [MAG_W-1:0]  diff [3];
    coord_t                   center [3];
    logic [MAG_W-1:0]         mag_or;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [31:0]       p32, p_rnd32, s_rnd32;
    vec_wide_t                rnd_w, side_w, t1_w;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [QUO_W-1:0]         quo;
    vec_t                     quo_sat;
    logic                     trig_done, sqrt_done, div_done;
    vec_t                     trig_sin, trig_cos;
    logic [ROOT_W-1:0]        root;
    logic                     in_take, out_free;

    // Shared CORDIC, one angle at a time: pitch, yaw, roll.
    ecb_cordic #(
        .ITER (TRIG_ITERATIONS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (trig_start_reg),
        .angle   (ang_reg[k_reg]),
        .done    (trig_done),
        .sin_val (trig_sin),
        .cos_val (trig_cos)
    );

    ecb_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start_reg),
        .rad   (sum_reg),
        .done  (sqrt_done),
        .root  (root)
    );

    ecb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num),
        .den   (root),
        .done  (div_done),
        .quo   (quo)
    );

    assign in_take  = item.valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        center[0] = item.center_x;
        center[1] = item.center_y;
        center[2] = item.center_z;
        for (int k = 0; k < 3; k++)
            diff[k] = {center[k][COORD_W-1], center[k]} - {pos_reg[k][COORD_W-1], pos_reg[k]};
        mag_or = mag_reg[0] | mag_reg[1] | mag_reg[2];

        // Operand select for the shared multiplier.
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_SQUARE)
        begin
            mul_a = $signed({1'b0, mag_reg[k_reg][NRM_W-1:0]});
            mul_b = $signed({1'b0, mag_reg[k_reg][NRM_W-1:0]});
        end
        else if (state_reg == S_MUL)
        begin
            case (step_reg)
                M_FX:    begin mul_a = sin_reg[1]; mul_b = cos_reg[0]; end
                M_FZ:    begin mul_a = cos_reg[1]; mul_b = cos_reg[0]; end
                M_T1A:   begin mul_a = cos_reg[1]; mul_b = sin_reg[2]; end
                M_T2A:   begin mul_a = sin_reg[1]; mul_b = sin_reg[0]; end
                M_UX:    begin mul_a = t2_reg;     mul_b = cos_reg[2]; end
                M_UY:    begin mul_a = cos_reg[0]; mul_b = cos_reg[2]; end
                M_T1B:   begin mul_a = sin_reg[1]; mul_b = sin_reg[2]; end
                M_T2B:   begin mul_a = sin_reg[0]; mul_b = cos_reg[2]; end
                M_UZ:    begin mul_a = t2_reg;     mul_b = cos_reg[1]; end
                M_SXA:   begin mul_a = fwd_reg[1]; mul_b = up_reg[2];  end
                M_SXB:   begin mul_a = fwd_reg[2]; mul_b = up_reg[1];  end
                M_SYA:   begin mul_a = fwd_reg[2]; mul_b = up_reg[0];  end
                M_SYB:   begin mul_a = fwd_reg[0]; mul_b = up_reg[2];  end
                M_SZA:   begin mul_a = fwd_reg[0]; mul_b = up_reg[1];  end
                M_SZB:   begin mul_a = fwd_reg[1]; mul_b = up_reg[0];  end
                default: begin mul_a = '0;         mul_b = '0;         end
            endcase
        end

        // Round a product once; a cross term rounds the exact difference.
        p32     = prod_reg[31:0];
        p_rnd32 = (p32 + HALF32) >>> FRAC_W;
        s_rnd32 = (acc_reg - p32 + HALF32) >>> FRAC_W;
        rnd_w   = p_rnd32[VEC_W+1:0];
        side_w  = s_rnd32[VEC_W+1:0];
        t1_w    = t1_reg;

        div_num = DIV_NUM_W'({mag_reg[k_reg][NRM_W-1:0], {FRAC_W{1'b0}}})
                + DIV_NUM_W'(root >> 1);
        quo_sat = (quo > QUO_W'(VEC_ONE)) ? VEC_ONE : vec_t'(quo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= M_FX;
            phase_reg      <= 1'b0;
            k_reg          <= '0;
            for (int k = 0; k < 3; k++)
            begin
                pos_reg[k]  <= '0;
                ang_reg[k]  <= '0;
                sin_reg[k]  <= '0;
                cos_reg[k]  <= '0;
                mag_reg[k]  <= '0;
                neg_reg[k]  <= 1'b0;
            end
            fwd_reg[0]     <= '0;
            fwd_reg[1]     <= '0;
            fwd_reg[2]     <= -VEC_ONE;
            up_reg[0]      <= '0;
            up_reg[1]      <= VEC_ONE;
            up_reg[2]      <= '0;
            side_reg[0]    <= VEC_ONE;
            side_reg[1]    <= '0;
            side_reg[2]    <= '0;
            trig_start_reg <= 1'b0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            t1_reg         <= '0;
            t2_reg         <= '0;
            sum_reg        <= '0;
            sqrt_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            degen_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < 9; k++)
                out_vec_reg[k] <= '0;
            out_degen_reg  <= 1'b0;
        end
        else
        begin
            trig_start_reg <= 1'b0;
            sqrt_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;

            // Position writes; unknown addresses drop.
            if (cfg.valid)
            begin
                case (reg_idx_t'(cfg.addr))
                    REG_POS_X: pos_reg[0] <= cfg.data;
                    REG_POS_Y: pos_reg[1] <= cfg.data;
                    REG_POS_Z: pos_reg[2] <= cfg.data;
                    default:   ;
                endcase
            end

            // Drop the result once taken, unless a new one loads this cycle.
            if (result.ready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        degen_reg  <= 1'b0;
                        ang_reg[0] <= item.pitch;
                        ang_reg[1] <= item.yaw;
                        ang_reg[2] <= item.roll;
                        for (int k = 0; k < 3; k++)
                        begin
                            neg_reg[k] <= diff[k][MAG_W-1];
                            mag_reg[k] <= diff[k][MAG_W-1] ? MAG_W'(-diff[k])
                                                           : MAG_W'(diff[k]);
                        end
                        k_reg <= '0;
                        if (item.command == CMD_LOOK)
                            state_reg <= S_CHECK;
                        else
                        begin
                            trig_start_reg <= 1'b1;
                            state_reg      <= S_TRIG;
                        end
                    end
                end

                S_TRIG:
                begin
                    if (trig_done)
                    begin
                        sin_reg[k_reg] <= trig_sin;
                        cos_reg[k_reg] <= trig_cos;
                        if (k_reg == 2'd2)
                        begin
                            fwd_reg[1] <= sin_reg[0];
                            step_reg   <= M_FX;
                            phase_reg  <= 1'b0;
                            state_reg  <= S_MUL;
                        end
                        else
                        begin
                            k_reg          <= k_reg + 1'b1;
                            trig_start_reg <= 1'b1;
                        end
                    end
                end

                S_MUL:
                begin
                    if (!phase_reg)
                    begin
                        prod_reg  <= mul_a * mul_b;
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                        step_reg  <= mstep_t'(step_reg + 1'b1);
                        case (step_reg)
                            M_FX:    fwd_reg[0]  <= clamp_vec(rnd_w);
                            M_FZ:    fwd_reg[2]  <= clamp_vec(-rnd_w);
                            M_T1A:   t1_reg      <= clamp_vec(rnd_w);
                            M_T2A:   t2_reg      <= clamp_vec(rnd_w);
                            M_UX:    up_reg[0]   <= clamp_vec(-t1_w - rnd_w);
                            M_UY:    up_reg[1]   <= clamp_vec(rnd_w);
                            M_T1B:   t1_reg      <= clamp_vec(rnd_w);
                            M_T2B:   t2_reg      <= clamp_vec(rnd_w);
                            M_UZ:    up_reg[2]   <= clamp_vec(-t1_w + rnd_w);
                            M_SXA:   acc_reg     <= p32;
                            M_SXB:   side_reg[0] <= clamp_vec(side_w);
                            M_SYA:   acc_reg     <= p32;
                            M_SYB:   side_reg[1] <= clamp_vec(side_w);
                            M_SZA:   acc_reg     <= p32;
                            M_SZB:
                            begin
                                side_reg[2] <= clamp_vec(side_w);
                                state_reg   <= S_DONE;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end

                S_CHECK:
                begin
                    if (mag_or == '0)
                    begin
                        for (int k = 0; k < 3; k++)
                            fwd_reg[k] <= '0;
                        degen_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_SCALE;
                end

                // Bring the largest magnitude into [2^23, 2^24), one bit a cycle.
                S_SCALE:
                begin
                    if (|mag_or[MAG_W-1:NRM_W])
                    begin
                        for (int k = 0; k < 3; k++)
                            mag_reg[k] <= mag_reg[k] >> 1;
                    end
                    else if (!mag_or[NRM_W-1])
                    begin
                        for (int k = 0; k < 3; k++)
                            mag_reg[k] <= mag_reg[k] << 1;
                    end
                    else
                    begin
                        k_reg     <= '0;
                        phase_reg <= 1'b0;
                        sum_reg   <= '0;
                        state_reg <= S_SQUARE;
                    end
                end

                S_SQUARE:
                begin
                    if (!phase_reg)
                    begin
                        prod_reg  <= mul_a * mul_b;
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                        sum_reg   <= sum_reg + SQ_W'(prod_reg[SQ_W-3:0]);
                        if (k_reg == 2'd2)
                        begin
                            sqrt_start_reg <= 1'b1;
                            state_reg      <= S_ROOT;
                        end
                        else
                            k_reg <= k_reg + 1'b1;
                    end
                end

                S_ROOT:
                begin
                    if (sqrt_done)
                    begin
                        k_reg         <= '0;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        fwd_reg[k_reg] <= neg_reg[k_reg] ? -quo_sat : quo_sat;
                        if (k_reg == 2'd2)
                            state_reg <= S_DONE;
                        else
                        begin
                            k_reg         <= k_reg + 1'b1;
                            div_start_reg <= 1'b1;
                        end
                    end
                end

                // Hold until the output register is free.
                S_DONE:
                begin
                    if (out_free)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            out_vec_reg[k]     <= fwd_reg[k];
                            out_vec_reg[3 + k] <= up_reg[k];
                            out_vec_reg[6 + k] <= side_reg[k];
                        end
                        out_degen_reg <= degen_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign cfg.ready         = 1'b1;
    assign item.ready        = (state_reg == S_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.dir_x      = out_vec_reg[0];
    assign result.dir_y      = out_vec_reg[1];
    assign result.dir_z      = out_vec_reg[2];
    assign result.up_x       = out_vec_reg[3];
    assign result.up_y       = out_vec_reg[4];
    assign result.up_z       = out_vec_reg[5];
    assign result.side_x     = out_vec_reg[6];
    assign result.side_y     = out_vec_reg[7];
    assign result.side_z     = out_vec_reg[8];
    assign result.degenerate = out_degen_reg;

    // A taken request keeps the block busy for at least the next cycle.
    `ECB_ASSERT(a_busy_after_take, clk, rst_n, item.valid && item.ready |=> !item.ready, "request taken but block still ready")
    // A degenerate look-at leaves a zero direction.
    `ECB_ASSERT(a_degen_zero_dir, clk, rst_n, result.valid && result.degenerate |-> (result.dir_x == 16'sd0) && (result.dir_y == 16'sd0) && (result.dir_z == 16'sd0), "degenerate result with nonzero direction")
    // The direction's x component stays in the unit range.
    `ECB_ASSERT(a_dir_range, clk, rst_n, result.valid |-> (result.dir_x <= VEC_ONE) && (result.dir_x >= -VEC_ONE), "direction x out of range")
    // Reset empties the output register.
    `ECB_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !result.valid, "result valid during reset")

endmodule
